// ===== rtl/supi_pkg.sv =====
// shared constants, types and helpers for the sphere union point inclusion block
package supi_pkg;

    localparam int MAX_SPHERES = 16384;
    localparam int COORD_BITS  = 32;

    localparam int FIELD_W = 32;
    localparam int OP_W    = 2;
    localparam int HELD_W  = 15;
    localparam int CNT_W   = $clog2(MAX_SPHERES + 1);
    localparam int ADDR_W  = (MAX_SPHERES > 1) ? $clog2(MAX_SPHERES) : 1;
    localparam int ENTRY_W = 4 * COORD_BITS;
    localparam int SQ_W    = 2 * COORD_BITS;
    localparam int SUM_W   = SQ_W + 2;
    localparam int CMP_W   = SUM_W + 2;

    localparam logic [FIELD_W-1:0] SAT_MAX = '1;

    typedef enum logic [OP_W-1:0] {
        OP_LOAD  = 2'd0,
        OP_TEST  = 2'd1,
        OP_CLEAR = 2'd2
    } t_op;

    typedef enum logic [1:0] {
        ST_IDLE = 2'b01,
        ST_SCAN = 2'b10
    } t_state;

    typedef struct packed {
        logic [COORD_BITS-1:0] x;
        logic [COORD_BITS-1:0] y;
        logic [COORD_BITS-1:0] z;
        logic [COORD_BITS-1:0] d;
    } t_entry;

    typedef struct packed {
        logic               inside_res;
        logic [FIELD_W-1:0] hit_total;
        logic [FIELD_W-1:0] trial_total;
        logic [HELD_W-1:0]  spheres_held;
        logic               status;
    } t_result;

    function automatic logic [FIELD_W-1:0] sat_inc(input logic [FIELD_W-1:0] v);
        return (v == SAT_MAX) ? v : v + 1'b1;
    endfunction

    function automatic logic [COORD_BITS-1:0] abs_diff(
        input logic [COORD_BITS-1:0] a,
        input logic [COORD_BITS-1:0] b
    );
        return (a >= b) ? a - b : b - a;
    endfunction

endpackage

// ===== rtl/supi_if.sv =====
// valid/ready channel interfaces for input and result words
interface supi_in_if;
    logic        valid;
    logic        ready;
    logic [1:0]  operation;
    logic [31:0] pos_x;
    logic [31:0] pos_y;
    logic [31:0] pos_z;
    logic [31:0] diameter;

    modport source (output valid, operation, pos_x, pos_y, pos_z, diameter, input ready);
    modport sink   (input valid, operation, pos_x, pos_y, pos_z, diameter, output ready);
endinterface

interface supi_out_if;
    logic        valid;
    logic        ready;
    logic        inside_res;
    logic [31:0] hit_total;
    logic [31:0] trial_total;
    logic [14:0] spheres_held;
    logic        status;

    modport source (output valid, inside_res, hit_total, trial_total, spheres_held, status,
                    input ready);
    modport sink   (input valid, inside_res, hit_total, trial_total, spheres_held, status,
                    output ready);
endinterface

// ===== rtl/sphere_union_point_inclusion.sv =====
// top level: sphere table in ram, pipelined point-in-sphere scan, saturating counters
//
// usage
//   i_in carries one word per item: operation (load sphere, test point, clear),
//   a Q16.16 position and, for loads, a Q16.16 diameter. o_out carries exactly
//   one result word per item: inside flag, hit and trial totals, sphere count
//   and a table-full status. both channels move a word when valid and ready
//   are high at a rising edge of i_clk.
//   load, clear, unused codes and a test of an empty table: the result word is
//   registered at the accepting edge itself, into the output register or,
//   while that still holds a stalled result, into the skid register.
//   a test of a non-empty table reads the table ram, one entry per cycle
//   from entry 0, through the distance pipeline behind it (diff, square,
//   sum, compare); the first hit or the last entry registers the result.
//   one item is worked on at a time; a new word is taken while the previous
//   result still waits in the output register, a skid register holds one
//   more result when the receiver stalls; input stalls then and during a scan.
//   i_rst_n (synchronous, low) empties the table and zeroes both counters at
//   once; the ram content is not cleared and needs no clearing pass.
module sphere_union_point_inclusion (
    input  logic     i_clk,
    input  logic     i_rst_n,
    supi_in_if.sink  i_in,
    supi_out_if.source o_out
);
    import supi_pkg::*;

    // control state
    t_state              r_state,   n_state;
    logic [CNT_W-1:0]    r_count,   n_count;
    logic [FIELD_W-1:0]  r_hits,    n_hits;
    logic [FIELD_W-1:0]  r_trials,  n_trials;
    logic [ADDR_W-1:0]   r_addr,    n_addr;
    logic                r_issue,   n_issue;
    logic                r_rd_v,    n_rd_v;
    logic                r_rd_last, n_rd_last;
    logic                r_v1, r_v2, r_v3;
    logic                r_last1, r_last2, r_last3;
    logic                r_out_v,   n_out_v;
    logic                r_pend_v,  n_pend_v;
    t_result             r_out,     n_out;
    t_result             r_pend,    n_pend;

    // test point held during the scan
    logic [COORD_BITS-1:0] r_px, r_py, r_pz;

    // distance pipeline data
    logic [COORD_BITS-1:0] r_dx, r_dy, r_dz, r_dm;
    logic [SQ_W-1:0]       r_sx, r_sy, r_sz, r_dsq2, r_dsq3;
    logic [SUM_W-1:0]      r_sum;

    logic                  accept;
    logic                  full;
    logic                  ram_we;
    t_entry                wr_entry;
    t_entry                rd_entry;
    logic                  hit3;
    logic                  flush;
    logic                  res_fire;
    t_result               res;
    logic [COORD_BITS-1:0] in_x, in_y, in_z, in_d;

    assign in_x = COORD_BITS'(i_in.pos_x);
    assign in_y = COORD_BITS'(i_in.pos_y);
    assign in_z = COORD_BITS'(i_in.pos_z);
    assign in_d = COORD_BITS'(i_in.diameter);

    assign i_in.ready = (r_state == ST_IDLE) && !r_pend_v;
    assign accept     = i_in.valid && i_in.ready;
    assign full       = (r_count == CNT_W'(MAX_SPHERES));

    // sphere table, one entry per sphere
    assign wr_entry = '{x: in_x, y: in_y, z: in_z, d: in_d};

    supi_ram #(
        .WIDTH (ENTRY_W),
        .DEPTH (MAX_SPHERES)
    ) u_table (
        .i_clk   (i_clk),
        .i_we    (ram_we),
        .i_waddr (r_count[ADDR_W-1:0]),
        .i_wdata (wr_entry),
        .i_raddr (r_addr),
        .o_rdata (rd_entry)
    );

    // 4*dist^2 < diameter^2, exact on the raw fixed-point values
    assign hit3 = r_v3 && ({r_sum, 2'b00} < CMP_W'(r_dsq3));

    always_comb begin
        n_state   = r_state;
        n_count   = r_count;
        n_hits    = r_hits;
        n_trials  = r_trials;
        n_addr    = r_addr;
        n_issue   = r_issue;
        n_rd_v    = 1'b0;
        n_rd_last = 1'b0;
        ram_we    = 1'b0;
        flush     = 1'b0;
        res_fire  = 1'b0;
        res       = '0;
        res.inside_res = 1'b0;
        res.status     = 1'b0;

        unique case (r_state)
            ST_IDLE: begin
                if (accept) begin
                    unique case (t_op'(i_in.operation))
                        OP_LOAD: begin
                            if (full) begin
                                res.status = 1'b1;
                            end else begin
                                ram_we  = 1'b1;
                                n_count = r_count + 1'b1;
                            end
                            res_fire = 1'b1;
                        end
                        OP_TEST: begin
                            if (r_count == '0) begin
                                n_trials = sat_inc(r_trials);
                                res_fire = 1'b1;
                            end else begin
                                n_state = ST_SCAN;
                                n_addr  = '0;
                                n_issue = 1'b1;
                            end
                        end
                        OP_CLEAR: begin
                            n_count  = '0;
                            n_hits   = '0;
                            n_trials = '0;
                            res_fire = 1'b1;
                        end
                        default: begin
                            // unused code: report the state as it stands
                            res_fire = 1'b1;
                        end
                    endcase
                end
            end
            ST_SCAN: begin
                // one table read per cycle until the last entry is issued
                if (r_issue) begin
                    n_rd_v    = 1'b1;
                    n_rd_last = ((CNT_W'(r_addr) + 1'b1) == r_count);
                    n_addr    = ADDR_W'(r_addr + 1'b1);
                    if (n_rd_last) begin
                        n_issue = 1'b0;
                    end
                end
                // first hit or last entry ends the scan and drops reads in flight
                if (hit3 || (r_v3 && r_last3)) begin
                    flush    = 1'b1;
                    n_rd_v   = 1'b0;
                    n_issue  = 1'b0;
                    n_state  = ST_IDLE;
                    n_trials = sat_inc(r_trials);
                    if (hit3) begin
                        n_hits         = sat_inc(r_hits);
                        res.inside_res = 1'b1;
                    end
                    res_fire = 1'b1;
                end
            end
            default: begin
                n_state = ST_IDLE;
                n_issue = 1'b0;
            end
        endcase

        res.hit_total    = n_hits;
        res.trial_total  = n_trials;
        res.spheres_held = HELD_W'(n_count);
    end

    // output register with one skid word behind it
    always_comb begin
        n_out_v  = r_out_v;
        n_pend_v = r_pend_v;
        n_out    = r_out;
        n_pend   = r_pend;
        if (res_fire) begin
            if (!r_out_v || o_out.ready) begin
                n_out   = res;
                n_out_v = 1'b1;
            end else begin
                n_pend   = res;
                n_pend_v = 1'b1;
            end
        end else if (r_out_v && o_out.ready) begin
            if (r_pend_v) begin
                n_out    = r_pend;
                n_pend_v = 1'b0;
            end else begin
                n_out_v = 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state   <= ST_IDLE;
            r_count   <= '0;
            r_hits    <= '0;
            r_trials  <= '0;
            r_addr    <= '0;
            r_issue   <= 1'b0;
            r_rd_v    <= 1'b0;
            r_rd_last <= 1'b0;
            r_v1      <= 1'b0;
            r_v2      <= 1'b0;
            r_v3      <= 1'b0;
            r_last1   <= 1'b0;
            r_last2   <= 1'b0;
            r_last3   <= 1'b0;
            r_out_v   <= 1'b0;
            r_pend_v  <= 1'b0;
        end else begin
            r_state   <= n_state;
            r_count   <= n_count;
            r_hits    <= n_hits;
            r_trials  <= n_trials;
            r_addr    <= n_addr;
            r_issue   <= n_issue;
            r_rd_v    <= n_rd_v;
            r_rd_last <= n_rd_last;
            r_v1      <= r_rd_v && !flush;
            r_v2      <= r_v1 && !flush;
            r_v3      <= r_v2 && !flush;
            r_last1   <= r_rd_last;
            r_last2   <= r_last1;
            r_last3   <= r_last2;
            r_out_v   <= n_out_v;
            r_pend_v  <= n_pend_v;
        end
    end

    // payload registers
    always_ff @(posedge i_clk) begin
        r_out  <= n_out;
        r_pend <= n_pend;
        if (accept) begin
            r_px <= in_x;
            r_py <= in_y;
            r_pz <= in_z;
        end
        // stage 1: absolute differences
        r_dx <= abs_diff(rd_entry.x, r_px);
        r_dy <= abs_diff(rd_entry.y, r_py);
        r_dz <= abs_diff(rd_entry.z, r_pz);
        r_dm <= rd_entry.d;
        // stage 2: squares, operands zero-extended so the full product is kept
        r_sx   <= SQ_W'(r_dx) * SQ_W'(r_dx);
        r_sy   <= SQ_W'(r_dy) * SQ_W'(r_dy);
        r_sz   <= SQ_W'(r_dz) * SQ_W'(r_dz);
        r_dsq2 <= SQ_W'(r_dm) * SQ_W'(r_dm);
        // stage 3: sum of squares
        r_sum  <= SUM_W'(r_sx) + SUM_W'(r_sy) + SUM_W'(r_sz);
        r_dsq3 <= r_dsq2;
    end

    assign o_out.valid        = r_out_v;
    assign o_out.inside_res   = r_out.inside_res;
    assign o_out.hit_total    = r_out.hit_total;
    assign o_out.trial_total  = r_out.trial_total;
    assign o_out.spheres_held = r_out.spheres_held;
    assign o_out.status       = r_out.status;
endmodule

// ===== rtl/supi_ram.sv =====
// generic single write port, single read port ram with registered read
module supi_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 1024
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);
    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;
endmodule

// ===== rtl/supi_chk.sv =====
// port-level checker for the sphere union point inclusion block, bound to the top level
module supi_chk (
    input logic        i_clk,
    input logic        i_rst_n,
    input logic        i_out_valid,
    input logic        i_out_ready,
    input logic        i_inside_res,
    input logic [31:0] i_hit_total,
    input logic [31:0] i_trial_total,
    input logic [14:0] i_spheres_held,
    input logic        i_status
);
    import supi_pkg::*;

    // a stalled result word stays offered
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid && !i_out_ready |=> i_out_valid)
        else $error("result word dropped while stalled");

    // hits never exceed trials
    a_hits_le_trials: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid |-> (i_hit_total <= i_trial_total))
        else $error("hit total above trial total");

    // an inside result has been counted
    a_inside_counted: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid && i_inside_res |-> (i_hit_total != '0) && (i_trial_total != '0))
        else $error("inside result without counted hit");

    // a rejected load only when the table is full, and never with a hit
    a_reject_full: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid && i_status |-> !i_inside_res && (i_spheres_held == HELD_W'(MAX_SPHERES)))
        else $error("load rejected with table not full");
endmodule

bind sphere_union_point_inclusion supi_chk u_supi_chk (
    .i_clk          (i_clk),
    .i_rst_n        (i_rst_n),
    .i_out_valid    (o_out.valid),
    .i_out_ready    (o_out.ready),
    .i_inside_res   (o_out.inside_res),
    .i_hit_total    (o_out.hit_total),
    .i_trial_total  (o_out.trial_total),
    .i_spheres_held (o_out.spheres_held),
    .i_status       (o_out.status)
);
